[src/gffrp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffrp_pkg
// shared constants, codes and controller/datapath interface types for the
// first-fit rectangle placer
// ----------------------------------------------------------------------------
package gffrp_pkg;

    // table depth, candidate grid pitch and largest atlas side
    localparam int MAX_RECTS = 64;
    localparam int GRID_STEP = 32;
    localparam int MAX_DIM   = 8192;

    localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W     = $clog2(MAX_RECTS + 1);
    localparam int DIM_W     = 14;
    localparam int POS_W     = 13;
    localparam int LIM_W     = 7;
    localparam int CFG_W     = 14;
    localparam int REG_IDX_W = 2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_ATLAS_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ATLAS_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_LIMIT  = 2'd2;

    // register reset values
    localparam logic [DIM_W-1:0] ATLAS_RESET = 14'd2048;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [1:0] {
        CAUSE_OK,
        CAUSE_FULL,
        CAUSE_LARGE,
        CAUSE_NOSPOT
    } t_cause;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic   load;
        logic   step;
        logic   commit;
        logic   emit;
        t_cause cause;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic too_large;
        logic spot_free;
        logic last_corner;
        logic out_free;
    } t_status;

endpackage

[src/gffrp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffrp_ctrl
// sequencer: checks, corner scan, result hand-off
// ----------------------------------------------------------------------------
module gffrp_ctrl import gffrp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state, n_state;
    t_cause r_cause, n_cause;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cause <= CAUSE_OK;
        end else begin
            r_state <= n_state;
            r_cause <= n_cause;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cause = r_cause;
        o_cmd   = '0;
        o_cmd.cause = r_cause;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // table full wins over size
                if (i_status.full) begin
                    n_cause = CAUSE_FULL;
                    n_state = ST_FINISH;
                end else if (i_status.too_large) begin
                    n_cause = CAUSE_LARGE;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.spot_free) begin
                    o_cmd.commit = 1'b1;
                    n_cause      = CAUSE_OK;
                    n_state      = ST_FINISH;
                end else if (i_status.last_corner) begin
                    n_cause = CAUSE_NOSPOT;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

[src/gffrp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffrp_datapath
// config registers, rectangle table lanes, corner counters, output register
// ----------------------------------------------------------------------------
module gffrp_datapath import gffrp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [DIM_W-1:0]     i_rect_width,
    input  logic [DIM_W-1:0]     i_rect_height,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_placed,
    output logic [POS_W-1:0]     o_pos_x,
    output logic [POS_W-1:0]     o_pos_y,
    output t_cause               o_fail_cause
);

    logic [DIM_W-1:0] r_atlas_w, r_atlas_h;
    logic [LIM_W-1:0] r_entry_limit;

    logic [DIM_W-1:0] r_rw, r_rh;
    logic [POS_W-1:0] r_x, r_y;
    logic [CNT_W-1:0] r_count;

    // one lane per stored rectangle: left, top, right edge, bottom edge
    logic [POS_W-1:0] r_xs [MAX_RECTS];
    logic [POS_W-1:0] r_ys [MAX_RECTS];
    logic [DIM_W-1:0] r_xe [MAX_RECTS];
    logic [DIM_W-1:0] r_ye [MAX_RECTS];

    logic             r_out_valid, r_out_placed;
    logic [POS_W-1:0] r_out_x, r_out_y;
    t_cause           r_out_cause;

    logic [DIM_W-1:0] w_aw, w_ah, w_xmax, w_ymax, w_next_x, w_next_y;
    logic [CNT_W-1:0] w_limit;
    logic [DIM_W:0]   w_cand_xe, w_cand_ye;
    logic [MAX_RECTS-1:0] w_hit;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w     <= ATLAS_RESET;
            r_atlas_h     <= ATLAS_RESET;
            r_entry_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ATLAS_WIDTH:  r_atlas_w     <= i_cfg_data[DIM_W-1:0];
                REG_ATLAS_HEIGHT: r_atlas_h     <= i_cfg_data[DIM_W-1:0];
                REG_ENTRY_LIMIT:  r_entry_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated atlas size and entry limit
    assign w_aw    = (int'(r_atlas_w) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_atlas_w;
    assign w_ah    = (int'(r_atlas_h) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_atlas_h;
    assign w_limit = (int'(r_entry_limit) > MAX_RECTS) ? CNT_W'(MAX_RECTS)
                                                       : CNT_W'(r_entry_limit);

    // scan bounds, only meaningful once the size check has passed
    assign w_xmax   = w_aw - r_rw;
    assign w_ymax   = w_ah - r_rh;
    assign w_next_x = DIM_W'(r_x) + DIM_W'(GRID_STEP);
    assign w_next_y = DIM_W'(r_y) + DIM_W'(GRID_STEP);

    assign w_cand_xe = (DIM_W+1)'(r_x) + (DIM_W+1)'(r_rw);
    assign w_cand_ye = (DIM_W+1)'(r_y) + (DIM_W+1)'(r_rh);

    // overlap test in every occupied lane
    always_comb begin
        for (int i = 0; i < MAX_RECTS; i++) begin
            w_hit[i] = (CNT_W'(i) < r_count) &&
                       !((DIM_W'(r_x) >= r_xe[i]) ||
                         (w_cand_xe <= (DIM_W+1)'(r_xs[i])) ||
                         (DIM_W'(r_y) >= r_ye[i]) ||
                         (w_cand_ye <= (DIM_W+1)'(r_ys[i])));
        end
    end

    assign o_status.full        = (r_count >= w_limit);
    assign o_status.too_large   = (r_rw == '0) || (r_rh == '0) ||
                                  (r_rw > w_aw) || (r_rh > w_ah);
    assign o_status.spot_free   = ~|w_hit;
    assign o_status.last_corner = (w_next_x > w_xmax) && (w_next_y > w_ymax);
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    // item capture and corner walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rw <= i_rect_width;
            r_rh <= i_rect_height;
            r_x  <= '0;
            r_y  <= '0;
        end else if (i_cmd.step) begin
            if (w_next_x <= w_xmax) begin
                r_x <= w_next_x[POS_W-1:0];
            end else begin
                r_x <= '0;
                r_y <= w_next_y[POS_W-1:0];
            end
        end
    end

    // table append
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_xs[r_count[IDX_W-1:0]] <= r_x;
            r_ys[r_count[IDX_W-1:0]] <= r_y;
            r_xe[r_count[IDX_W-1:0]] <= w_cand_xe[DIM_W-1:0];
            r_ye[r_count[IDX_W-1:0]] <= w_cand_ye[DIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= r_count + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_placed <= (i_cmd.cause == CAUSE_OK);
            r_out_x      <= (i_cmd.cause == CAUSE_OK) ? r_x : '0;
            r_out_y      <= (i_cmd.cause == CAUSE_OK) ? r_y : '0;
            r_out_cause  <= i_cmd.cause;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_placed     = r_out_placed;
    assign o_pos_x      = r_out_x;
    assign o_pos_y      = r_out_y;
    assign o_fail_cause = r_out_cause;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_RECTS)
        else $error("rectangle count beyond table depth");

    a_commit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_count == $past(r_count) + 1'b1)
        else $error("append did not advance count");

    a_commit_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (o_status.spot_free && !o_status.full))
        else $error("append into a full table or onto an occupied spot");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_status.out_free)
        else $error("pending result overwritten");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !o_status.last_corner)
        else $error("corner walk stepped past the last corner");

endmodule

[src/grid_first_fit_rect_placer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_first_fit_rect_placer
// first-fit rectangle placement into a 2d atlas on a fixed corner grid
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+------------------------------
//  in       | input     | i_in_valid / o_in_stall   | rect_width, rect_height
//  out      | output    | o_out_valid / i_out_stall | placed, pos_x, pos_y, fail_cause
//  cfg      | input     | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
//  steps: capture, check, corner scan, hand-off; a full table or an oversized
//    rectangle skips the scan and goes straight from the check to the hand-off
//  the corner scan sets the rate: each cycle one corner is tested against all
//    stored rectangles at once, one comparator lane per table entry
//  reset: synchronous, clears the count and restores the register defaults;
//    no clearing pass, lanes above the count are simply ignored
//  stalls: o_in_stall is high while an item is in work; a finished result waits
//    in the output register and the next word may be taken meanwhile
// ----------------------------------------------------------------------------
module grid_first_fit_rect_placer import gffrp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // rectangle request
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [DIM_W-1:0]     i_rect_width,
    input  logic [DIM_W-1:0]     i_rect_height,
    // placement result
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_placed,
    output logic [POS_W-1:0]     o_pos_x,
    output logic [POS_W-1:0]     o_pos_y,
    output logic [1:0]           o_fail_cause
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy;
    t_cause  w_cause;

    // sequencer: capture, limit/size checks, corner walk, hand-off
    gffrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    // table lanes, corner counters and the result register
    gffrp_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_placed      (o_placed),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_fail_cause  (w_cause)
    );

    // one item in work at a time; stall comes straight from the state register
    assign o_in_stall   = w_busy;
    assign o_fail_cause = w_cause;

endmodule

[tb/placement_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// placement_checker
// watches the register, request and result ports of the rectangle placer,
// predicts every result by its own first-fit search over a private copy of
// the stored rectangles and compares the results in order, field by field
// ----------------------------------------------------------------------------
module placement_checker import gffrp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [DIM_W-1:0]     i_rect_width,
    input  logic [DIM_W-1:0]     i_rect_height,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_placed,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [1:0]           i_fail_cause,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_placed_count,
    output int                   o_full_count,
    output int                   o_large_count,
    output int                   o_nospot_count
);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
    } t_stored_rect;

    typedef struct packed {
        logic             placed;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        t_cause           cause;
    } t_placement;

    t_stored_rect     atlas_rects [MAX_RECTS];
    int               rect_total;
    logic [DIM_W-1:0] atlas_w;
    logic [DIM_W-1:0] atlas_h;
    logic [LIM_W-1:0] rect_cap;
    t_placement       placements_due [$];

    function automatic bit corner_is_free(int cx, int cy, int rw, int rh);
        int  i;
        int  ox, oy, ow, oh;
        bit  apart;
        for (i = 0; i < rect_total; i++) begin
            ox = int'(atlas_rects[i].x);
            oy = int'(atlas_rects[i].y);
            ow = int'(atlas_rects[i].w);
            oh = int'(atlas_rects[i].h);
            apart = (cx >= ox + ow) || (cx + rw <= ox) || (cy >= oy + oh) || (cy + rh <= oy);
            if (!apart)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // first fit, rows outer and columns inner; stores the rectangle on success
    function automatic t_placement place_rect(int rw, int rh);
        t_placement   res;
        t_stored_rect fresh;
        int           aw, ah, cap, cx, cy;
        bit           found;
        aw    = (int'(atlas_w) > MAX_DIM) ? MAX_DIM : int'(atlas_w);
        ah    = (int'(atlas_h) > MAX_DIM) ? MAX_DIM : int'(atlas_h);
        cap   = (int'(rect_cap) > MAX_RECTS) ? MAX_RECTS : int'(rect_cap);
        res   = '0;
        res.cause = CAUSE_NOSPOT;
        found = 1'b0;
        if (rect_total >= cap) begin
            res.cause = CAUSE_FULL;
        end else if (rw == 0 || rh == 0 || rw > aw || rh > ah) begin
            res.cause = CAUSE_LARGE;
        end else begin
            for (cy = 0; cy + rh <= ah && !found; cy += GRID_STEP) begin
                for (cx = 0; cx + rw <= aw && !found; cx += GRID_STEP) begin
                    if (corner_is_free(cx, cy, rw, rh)) begin
                        found      = 1'b1;
                        res.placed = 1'b1;
                        res.pos_x  = cx[POS_W-1:0];
                        res.pos_y  = cy[POS_W-1:0];
                        res.cause  = CAUSE_OK;
                        fresh.x    = cx[15:0];
                        fresh.y    = cy[15:0];
                        fresh.w    = rw[15:0];
                        fresh.h    = rh[15:0];
                        atlas_rects[rect_total] = fresh;
                        rect_total++;
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_placement want;
        if (!i_rst_n) begin
            rect_total = 0;
            atlas_w    = ATLAS_RESET;
            atlas_h    = ATLAS_RESET;
            rect_cap   = LIMIT_RESET;
            placements_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ATLAS_WIDTH:  atlas_w  = i_cfg_data[DIM_W-1:0];
                    REG_ATLAS_HEIGHT: atlas_h  = i_cfg_data[DIM_W-1:0];
                    REG_ENTRY_LIMIT:  rect_cap = i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (placements_due.size() == 0) begin
                    $error("result word with nothing expected: placed %0d x %0d y %0d cause %0d",
                           i_placed, i_pos_x, i_pos_y, i_fail_cause);
                    o_fail_count++;
                end else begin
                    want = placements_due.pop_front();
                    if (i_placed !== want.placed) begin
                        $error("placed: expected %0d, got %0d", want.placed, i_placed);
                        o_fail_count++;
                    end
                    if (i_pos_x !== want.pos_x) begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, i_pos_x);
                        o_fail_count++;
                    end
                    if (i_pos_y !== want.pos_y) begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, i_pos_y);
                        o_fail_count++;
                    end
                    if (i_fail_cause !== want.cause) begin
                        $error("fail_cause: expected %0d, got %0d", want.cause, i_fail_cause);
                        o_fail_count++;
                    end
                    case (want.cause)
                        CAUSE_OK:    o_placed_count++;
                        CAUSE_FULL:  o_full_count++;
                        CAUSE_LARGE: o_large_count++;
                        default:     o_nospot_count++;
                    endcase
                end
            end
            if (i_in_valid && !i_in_stall)
                placements_due.push_back(place_rect(int'(i_rect_width), int'(i_rect_height)));
        end
        o_pending = placements_due.size();
    end

endmodule

[tb/grid_first_fit_rect_placer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_first_fit_rect_placer_tb
// drives rectangle requests and register writes into the placer, with random
// gaps on the request side and random stalls on the result side; a checker
// beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module grid_first_fit_rect_placer_tb;
    import gffrp_pkg::*;

    // index with no register behind it, writes there must change nothing
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 20;
    // one long result-side hold-off, early in the first random phase
    localparam int LONG_HOLD     = 300;
    localparam int LONG_HOLD_AT  = 25;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [DIM_W-1:0]     rect_w;
    logic [DIM_W-1:0]     rect_h;
    logic                 out_valid;
    logic                 out_stall;
    logic                 placed;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [1:0]           fail_cause;

    int fail_count;
    int pending;
    int n_placed;
    int n_full;
    int n_large;
    int n_nospot;

    int items_offered;
    int results_taken;
    int writes_made;
    // no gaps and no stalls while set
    bit quiet;
    bit long_hold_done;

    grid_first_fit_rect_placer uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_rect_width  (rect_w),
        .i_rect_height (rect_h),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_placed      (placed),
        .o_pos_x       (pos_x),
        .o_pos_y       (pos_y),
        .o_fail_cause  (fail_cause)
    );

    placement_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_rect_width   (rect_w),
        .i_rect_height  (rect_h),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_placed       (placed),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_fail_cause   (fail_cause),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_placed_count (n_placed),
        .o_full_count   (n_full),
        .o_large_count  (n_large),
        .o_nospot_count (n_nospot)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run (a few full 8192 scans included)
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // register write, one cycle of enable, after which the task waits with the enable low before it returns
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        writes_made++;
    endtask

    // one request word; valid stays high afterwards so back-to-back words need no dip
    task automatic offer_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rect_w   <= w;
        rect_h   <= h;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_offered++;
    endtask

    // stop offering and wait for every outstanding result, then let the block settle
    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // result side: random stall before each word, one long hold-off
    initial begin : result_sink
        int unsigned hold;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            hold = quiet ? 0 : $urandom_range(0, 14);
            if (!long_hold_done && results_taken == LONG_HOLD_AT) begin
                // the block finishes one word, takes the next and then stalls its input
                hold           = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            results_taken++;
        end
    end

    initial begin : stimulus
        logic [DIM_W-1:0] aw;
        logic [DIM_W-1:0] ah;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [LIM_W-1:0] cap;
        logic [6:0]       junk;
        int               pick;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ATLAS_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rect_w    = 14'd1;
        rect_h    = 14'd1;
        quiet     = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: 2048 square atlas, 64 entries
        // zero sides and oversize rectangles are refused before any scan
        offer_rect(14'd0, 14'd5);
        offer_rect(14'd5, 14'd0);
        offer_rect(14'd2049, 14'd10);
        offer_rect(14'd10, 14'd2049);
        offer_rect(14'h3FFF, 14'h3FFF);
        // first rectangle lands on the origin
        offer_rect(14'd1, 14'd1);
        // whole atlas, and nearly whole: only the origin corner, which is taken
        offer_rect(14'd2048, 14'd2048);
        offer_rect(14'd2047, 14'd2048);
        drain;

        // one-corner 32 by 32 atlas, limit above the table depth, a write to the spare index
        write_reg(REG_SPARE, 14'h3FFF);
        write_reg(REG_ATLAS_WIDTH, 14'd32);
        write_reg(REG_ATLAS_HEIGHT, 14'd32);
        write_reg(REG_ENTRY_LIMIT, 14'd127);
        offer_rect(14'd32, 14'd32);
        offer_rect(14'd33, 14'd1);
        offer_rect(14'd1, 14'd33);
        offer_rect(14'd31, 14'd31);
        drain;

        // zero-width atlas: nothing fits
        write_reg(REG_ATLAS_WIDTH, 14'd0);
        offer_rect(14'd1, 14'd1);
        drain;

        // table full wins over every other check, also over a bad size
        write_reg(REG_ATLAS_WIDTH, 14'd64);
        write_reg(REG_ENTRY_LIMIT, 14'd0);
        offer_rect(14'd1, 14'd1);
        offer_rect(14'd0, 14'd0);
        offer_rect(14'h3FFF, 14'h3FFF);
        drain;
        // limit equal to the present count
        write_reg(REG_ENTRY_LIMIT, 14'd1);
        offer_rect(14'd5, 14'd5);
        drain;

        // random phases on small atlases so scans stay short; the limit never goes
        // above 56 here, leaving room in the table for the big-atlas phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiet = (p == 3);
            aw    = DIM_W'($urandom_range(32, 640));
            ah    = DIM_W'($urandom_range(32, 640));
            cap   = LIM_W'((p == 2) ? $urandom_range(0, 24) : $urandom_range(40, 56));
            junk  = 7'($urandom_range(0, 127));
            write_reg(REG_ATLAS_WIDTH, aw);
            write_reg(REG_ATLAS_HEIGHT, ah);
            // upper data bits are ignored by the limit register
            write_reg(REG_ENTRY_LIMIT, {junk, cap});
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // once, the sender stops until the result side has caught up
                if (p == 1 && k == PHASE_ITEMS / 2)
                    drain;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    w = DIM_W'($urandom_range(1, aw / 3 + 1));
                    h = DIM_W'($urandom_range(1, ah / 3 + 1));
                end else if (pick < 85) begin
                    w = DIM_W'($urandom_range(1, aw));
                    h = DIM_W'($urandom_range(1, ah));
                end else if (pick < 95) begin
                    // any 14-bit size, mostly oversize
                    w = DIM_W'($urandom_range(0, 16383));
                    h = DIM_W'($urandom_range(0, 16383));
                end else begin
                    w = DIM_W'($urandom_range(0, 16383));
                    h = DIM_W'($urandom_range(0, 16383));
                    if ($urandom_range(0, 1))
                        w = '0;
                    else
                        h = '0;
                end
                offer_rect(w, h);
            end
            drain;
        end
        quiet = 1'b0;

        // largest atlas: corners far from the origin and long scans
        write_reg(REG_ATLAS_WIDTH, 14'd8192);
        write_reg(REG_ATLAS_HEIGHT, 14'd8192);
        write_reg(REG_ENTRY_LIMIT, 14'd127);
        offer_rect(14'd8192, 14'd8192);
        offer_rect(14'd8193, 14'd5);
        offer_rect(14'd1, 14'd8192);
        // full-width strip is blocked on every row by the full-height one
        offer_rect(14'd8192, 14'd1);
        offer_rect(14'd4096, 14'd4096);
        drain;

        // atlas sides above the largest size behave as the largest size
        write_reg(REG_ATLAS_WIDTH, 14'h3FFF);
        write_reg(REG_ATLAS_HEIGHT, 14'h3FFF);
        offer_rect(14'd8192, 14'd8192);
        offer_rect(14'h3FFF, 14'd1);
        drain;

        $display("run covered %0d rectangles and %0d register writes, atlas sides 0 to 16383",
                 items_offered, writes_made);
        $display("outcomes: %0d placed, %0d table full, %0d too large, %0d no free spot",
                 n_placed, n_full, n_large, n_nospot);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
